// ===== rtl/wth_pkg.sv =====
// ----------------------------------------------------------------------------
// wth_pkg
// Shared constants, types and hash helpers for the word tokenizer and hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wth_pkg;

  // Default sizing.
  localparam int MAX_WORD_LEN = 100;
  localparam int FIFO_DEPTH   = 4;

  // Hash mode codes.
  localparam logic MODE_CRC = 1'b0;
  localparam logic MODE_FNV = 1'b1;

  // Letter classification.
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] LETTER_A    = 8'h61;
  localparam logic [7:0] ALPHA_COUNT = 8'd26;

  // Hash constants.
  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
  localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME   = 32'd16777619;
  localparam logic [63:0] MIX_C1      = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MIX_C2      = 64'hc4ce_b9fe_1a85_ec53;

  // One finished word as it travels from the front end to the mixer.
  typedef struct packed {
    logic [31:0] hash;
    logic [6:0]  len;
    logic        mode;
  } word_rec_t;

  function automatic logic ascii_letter(input logic [7:0] c);
    logic [7:0] off;
    off = (c | CASE_BIT) - LETTER_A;
    return off < ALPHA_COUNT;
  endfunction

  // Bit-serial reflected CRC32C, one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] fnv1a_byte(input logic [31:0] h,
                                             input logic [7:0]  b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] seed_for(input logic mode);
    return (mode == MODE_FNV) ? FNV_BASIS : 32'd0;
  endfunction

endpackage

// ===== rtl/wth_if.sv =====
// ----------------------------------------------------------------------------
// wth_if
// Handshake channels of the word tokenizer: bytes in, words out, mode write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wth_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wth_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_hash;
  logic [15:0] fingerprint;
  logic [6:0]  word_length;

  modport source (output valid, output word_hash, output fingerprint,
                  output word_length, input ready);
  modport sink   (input valid, input word_hash, input fingerprint,
                  input word_length, output ready);
endinterface

interface wth_cfg_if;
  logic valid;
  logic ready;
  logic hash_mode;

  modport source (output valid, output hash_mode, input ready);
  modport sink   (input valid, input hash_mode, output ready);
endinterface

// ===== rtl/wth_fifo.sv =====
// ----------------------------------------------------------------------------
// wth_fifo
// Small register queue of finished words between the front end and mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wth_fifo #(
  parameter int DEPTH = wth_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wth_pkg::word_rec_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output wth_pkg::word_rec_t pop_data_o,
  output logic              empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  wth_pkg::word_rec_t mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/wth_front.sv =====
// ----------------------------------------------------------------------------
// wth_front
// Byte classifier and running hash; queues one record per finished word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wth_front #(
  parameter int MAX_WORD_LEN = wth_pkg::MAX_WORD_LEN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wth_byte_if.sink           byte_i,
  wth_cfg_if.sink            cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output wth_pkg::word_rec_t push_data_o
);

  localparam int LenW = $clog2(MAX_WORD_LEN);

  logic            mode_q;
  logic [31:0]     acc_q;
  logic [LenW-1:0] len_q;

  logic [7:0]      lower;
  logic            letter, room, keep, word_end, take;
  logic [31:0]     acc_upd, acc_new;
  logic [LenW-1:0] len_new;
  logic [LenW+6:0] len_ext;

  // A mode write takes the cycle, so no byte is taken alongside it.
  assign byte_i.ready = !full_i && !cfg_i.valid;
  assign cfg_i.ready  = 1'b1;

  assign take    = byte_i.valid && byte_i.ready;
  assign letter  = wth_pkg::ascii_letter(byte_i.byte_value);
  assign lower   = byte_i.byte_value | wth_pkg::CASE_BIT;
  assign room    = len_q < LenW'(MAX_WORD_LEN - 1);
  assign keep    = letter && room;
  assign acc_upd = (mode_q == wth_pkg::MODE_FNV) ? wth_pkg::fnv1a_byte(acc_q, lower)
                                                  : wth_pkg::crc32c_byte(acc_q, lower);
  assign acc_new = keep ? acc_upd : acc_q;
  assign len_new = keep ? len_q + 1'b1 : len_q;

  // A separator, or the last byte of a chunk, closes the pending word.
  assign word_end = !letter || byte_i.last_byte;
  assign len_ext  = {7'd0, len_new};

  assign push_o           = take && word_end && (len_new != '0);
  assign push_data_o.hash = acc_new;
  assign push_data_o.len  = len_ext[6:0];
  assign push_data_o.mode = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= wth_pkg::MODE_CRC;
      acc_q  <= '0;
      len_q  <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      mode_q <= cfg_i.hash_mode;
      acc_q  <= wth_pkg::seed_for(cfg_i.hash_mode);
      len_q  <= '0;
    end else if (take) begin
      if (word_end) begin
        acc_q <= wth_pkg::seed_for(mode_q);
        len_q <= '0;
      end else begin
        acc_q <= acc_new;
        len_q <= len_new;
      end
    end
  end

endmodule

// ===== rtl/wth_back.sv =====
// ----------------------------------------------------------------------------
// wth_back
// Avalanche mixer and output register; one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wth_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  wth_pkg::word_rec_t rec_i,
  output logic               pop_o,
  wth_word_if.source         word_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // Mix schedule: v*C1 in two halves, then (h1 ^ h1>>33)*C2 in three.
  localparam logic [2:0] MIX_LO1 = 3'd0;
  localparam logic [2:0] MIX_HI1 = 3'd1;
  localparam logic [2:0] MIX_H1  = 3'd2;
  localparam logic [2:0] MIX_LL2 = 3'd3;
  localparam logic [2:0] MIX_LH2 = 3'd4;
  localparam logic [2:0] MIX_HL2 = 3'd5;
  localparam logic [2:0] MIX_H2  = 3'd6;

  logic [1:0]  state_q;
  logic [2:0]  step_q;
  logic [31:0] v_q;
  logic [63:0] a_q, prod_q, sum_q;
  logic [31:0] res_q;
  logic [6:0]  len_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] product, acc_sum, mixed;

  always_comb begin
    case (step_q)
      MIX_LO1: begin mul_a = v_q;        mul_b = wth_pkg::MIX_C1[31:0];  end
      MIX_HI1: begin mul_a = v_q;        mul_b = wth_pkg::MIX_C1[63:32]; end
      MIX_LL2: begin mul_a = a_q[31:0];  mul_b = wth_pkg::MIX_C2[31:0];  end
      MIX_LH2: begin mul_a = a_q[31:0];  mul_b = wth_pkg::MIX_C2[63:32]; end
      MIX_HL2: begin mul_a = a_q[63:32]; mul_b = wth_pkg::MIX_C2[31:0];  end
      default: begin mul_a = '0;         mul_b = '0;                     end
    endcase
  end

  assign product = {32'd0, mul_a} * {32'd0, mul_b};
  // Cross products only reach the upper half of the 64-bit result.
  assign acc_sum = sum_q + {prod_q[31:0], 32'd0};
  assign mixed   = acc_sum ^ (acc_sum >> 33);

  assign pop_o              = (state_q == ST_IDLE) && !empty_i;
  assign word_o.valid       = (state_q == ST_OUT);
  assign word_o.word_hash   = res_q;
  assign word_o.fingerprint = res_q[15:0] ^ res_q[31:16];
  assign word_o.word_length = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            step_q  <= MIX_LO1;
            state_q <= (rec_i.mode == wth_pkg::MODE_FNV) ? ST_OUT : ST_MIX;
          end
        end
        ST_MIX: begin
          step_q <= step_q + 1'b1;
          if (step_q == MIX_H2) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (word_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !empty_i) begin
      len_q <= rec_i.len;
      v_q   <= rec_i.hash;
      res_q <= rec_i.hash;
    end
    if (state_q == ST_MIX) begin
      prod_q <= product;
      case (step_q)
        MIX_HI1: sum_q <= prod_q;
        MIX_H1:  a_q   <= mixed;
        MIX_LH2: sum_q <= prod_q;
        MIX_HL2: sum_q <= acc_sum;
        MIX_H2:  res_q <= mixed[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/word_tokenizer_hasher_core.sv =====
// ----------------------------------------------------------------------------
// word_tokenizer_hasher_core
// Splits a byte stream into lower-cased words and emits a hash per word.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle whenever the word queue (FIFO_DEPTH words)
// has room and no mode write is offered; letters update a running CRC32C or
// FNV-1a hash in the same cycle.
// Each finished word then passes the mixer: an FNV-1a word is popped and
// offered as is, a CRC32C word first runs the seven steps of the 64-bit
// avalanche mix through a single shared 32x32 multiplier; a word is held while
// the output side stalls, and no new word is popped until it is taken. Byte
// intake stops when the queue is full or a mode write is offered, so it keeps
// one byte per cycle only while the mixer drains words as fast as they finish.
// Mode writes clear the pending word and are expected while the block is idle.
`timescale 1ns / 1ps

module word_tokenizer_hasher_core #(
  parameter int MAX_WORD_LEN = wth_pkg::MAX_WORD_LEN,
  parameter int FIFO_DEPTH   = wth_pkg::FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wth_byte_if.sink  byte_i,
  wth_cfg_if.sink   cfg_i,
  wth_word_if.source word_o
);

  logic               push, full, pop, empty;
  wth_pkg::word_rec_t push_data, pop_data;

  wth_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .cfg_i      (cfg_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  wth_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  wth_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .rec_i  (pop_data),
    .pop_o  (pop),
    .word_o (word_o)
  );

endmodule

// ===== rtl/wth_checker.sv =====
// ----------------------------------------------------------------------------
// wth_checker
// Port-level assertions for the word tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wth_checker #(
  parameter int MAX_WORD_LEN = wth_pkg::MAX_WORD_LEN
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] word_hash_i,
  input logic [15:0] fingerprint_i,
  input logic [6:0]  word_length_i
);

  // A word that waits must stay offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(word_hash_i) && $stable(word_length_i))
    else $error("output word changed while stalled");

  // The fingerprint is always folded from the hash shown with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fingerprint_i == (word_hash_i[15:0] ^ word_hash_i[31:16]))
    else $error("fingerprint does not match hash");

  // Checked only for a limit below 128: no empty word is emitted and lengths stay under the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (MAX_WORD_LEN >= 128) ||
                    (word_length_i != 7'd0 && word_length_i < 7'(MAX_WORD_LEN)))
    else $error("word length out of range");

endmodule

bind word_tokenizer_hasher_core wth_checker #(
  .MAX_WORD_LEN(MAX_WORD_LEN)
) u_wth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (word_o.valid),
  .out_ready_i  (word_o.ready),
  .word_hash_i  (word_o.word_hash),
  .fingerprint_i(word_o.fingerprint),
  .word_length_i(word_o.word_length)
);

// ===== dv/word_tokenizer_hasher_core_test.sv =====
// ----------------------------------------------------------------------------
// word_tokenizer_hasher_core_test
// Drives byte streams and hash mode writes into the word tokenizer and checks
// every emitted word against a cycle-free model of the tokenizer kept here.
// A short table of directed bytes comes first, then random text made mostly
// of well-formed words, with bursty input and a stalling word receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_tokenizer_hasher_core_test;

  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 140;

  // Length column of the directed table: predicted, no word, or a typed length.
  localparam logic [6:0] LEN_PRED = 7'd127;
  localparam logic [6:0] LEN_NONE = 7'd0;

  typedef enum logic [1:0] {ROW_BYTE, ROW_RUN, ROW_MODE} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_RANDOM, RX_LONG} rx_style_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;
    logic       is_last;
    logic [7:0] count;
    logic [6:0] exp_len;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] fp;
    logic [6:0]  len;
  } word_exp_t;

  localparam int DIR_ROWS = 27;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, 8'h20, 1'b0, 8'd0,   LEN_NONE},  // separator right after reset
    '{ROW_BYTE, 8'h00, 1'b1, 8'd0,   LEN_NONE},  // last byte with nothing held
    '{ROW_BYTE, 8'h41, 1'b1, 8'd0,   7'd1},
    '{ROW_BYTE, 8'h7A, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'h5A, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'h61, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'h80, 1'b0, 8'd0,   7'd3},
    '{ROW_BYTE, 8'h40, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_BYTE, 8'h5B, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_BYTE, 8'h60, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_BYTE, 8'h7B, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_BYTE, 8'h4D, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'hC3, 1'b0, 8'd0,   7'd1},
    '{ROW_BYTE, 8'h65, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'hA9, 1'b0, 8'd0,   7'd1},
    '{ROW_RUN,  8'h71, 1'b0, 8'd100, LEN_PRED},
    '{ROW_BYTE, 8'hFF, 1'b1, 8'd0,   7'd99},
    '{ROW_BYTE, 8'h6B, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_MODE, 8'(wth_pkg::MODE_FNV), 1'b0, 8'd0, LEN_PRED},  // drops the pending word
    '{ROW_BYTE, 8'h2E, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_BYTE, 8'h48, 1'b0, 8'd0,   LEN_PRED},
    '{ROW_BYTE, 8'h69, 1'b1, 8'd0,   7'd2},
    '{ROW_BYTE, 8'hE1, 1'b0, 8'd0,   LEN_NONE},
    '{ROW_RUN,  8'h5A, 1'b0, 8'd100, LEN_PRED},
    '{ROW_BYTE, 8'h0A, 1'b0, 8'd0,   7'd99},
    '{ROW_MODE, 8'(wth_pkg::MODE_CRC), 1'b0, 8'd0, LEN_PRED},
    '{ROW_BYTE, 8'h79, 1'b1, 8'd0,   7'd1}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  wth_byte_if byte_if ();
  wth_cfg_if  cfg_if ();
  wth_word_if word_if ();

  word_tokenizer_hasher_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cfg_i  (cfg_if),
    .word_o (word_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tokenizer state as the block should hold it.
  logic        mode_q;
  logic [31:0] acc_q;
  int unsigned held_q;

  word_exp_t words_due [$];
  int        mismatch_count = 0;

  // Sender burst state.
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;

  // Receiver stall state.
  rx_style_e   rx_style;
  logic [7:0]  rx_pat;
  int unsigned rx_cnt = 0;

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) c = c ^ wth_pkg::CRC32C_POLY;
    end
    return c;
  endfunction

  function automatic logic [31:0] mix64(input logic [31:0] v);
    logic [63:0] h;
    h = {32'd0, v};
    h = h ^ (h >> 33);
    h = h * wth_pkg::MIX_C1;
    h = h ^ (h >> 33);
    h = h * wth_pkg::MIX_C2;
    h = h ^ (h >> 33);
    return h[31:0];
  endfunction

  function automatic logic [31:0] start_value(input logic m);
    return (m == wth_pkg::MODE_FNV) ? wth_pkg::FNV_BASIS : 32'd0;
  endfunction

  function automatic logic [7:0] pick_sep();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_alpha(b));
    return b;
  endfunction

  task automatic close_word();
    logic [31:0] h;
    if (held_q == 0) return;
    h = (mode_q == wth_pkg::MODE_FNV) ? acc_q : mix64(acc_q);
    words_due.push_back('{hash: h, fp: h[15:0] ^ h[31:16], len: 7'(held_q)});
    held_q = 0;
    acc_q  = start_value(mode_q);
  endtask

  // Advances the tokenizer by one accepted byte. A typed length from the
  // directed table overrides the predicted one and must agree on whether a
  // word comes out at all.
  task automatic tokenize_byte(input logic [7:0] b, input logic is_last,
                               input logic [6:0] exp_len);
    int  due_prior;
    logic [7:0] lc;
    bit  made;
    due_prior = words_due.size();
    if (is_alpha(b)) begin
      if (held_q < wth_pkg::MAX_WORD_LEN - 1) begin
        lc = b | wth_pkg::CASE_BIT;
        acc_q = (mode_q == wth_pkg::MODE_FNV) ? (acc_q ^ {24'd0, lc}) * wth_pkg::FNV_PRIME
                                              : crc_step(acc_q, lc);
        held_q++;
      end
      if (is_last) close_word();
    end else begin
      close_word();
    end
    if (exp_len != LEN_PRED) begin
      made = words_due.size() != due_prior;
      if (made == (exp_len == LEN_NONE)) begin
        $display("%0t directed byte %h: expected length %0d, predicted word %0d",
                 $time, b, exp_len, made);
        mismatch_count++;
      end else if (made) begin
        words_due[words_due.size() - 1].len = exp_len;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last,
                           input logic [6:0] exp_len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, 12));
      if (gap > 0) begin
        @(negedge clk_i);
        byte_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    byte_if.valid      = 1'b1;
    byte_if.byte_value = b;
    byte_if.last_byte  = is_last;
    do @(posedge clk_i); while (!byte_if.ready);
    tokenize_byte(b, is_last, exp_len);
  endtask

  // Mode writes go in only with no word due and the mixer drained.
  task automatic wait_idle();
    @(negedge clk_i);
    byte_if.valid = 1'b0;
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_if.valid     = 1'b1;
    cfg_if.hash_mode = m;
    do @(posedge clk_i); while (!cfg_if.ready);
    mode_q = m;
    acc_q  = start_value(m);
    held_q = 0;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Receiver: a new random stall style at the end of each run of random length.
  always @(negedge clk_i) begin
    if (rx_cnt == 0) begin
      rx_cnt   = $urandom_range(16, 96);
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_pat   = 8'($urandom);
    end
    rx_cnt--;
    case (rx_style)
      RX_OPEN:    word_if.ready = 1'b1;
      RX_PATTERN: word_if.ready = rx_pat[rx_cnt % 8];
      RX_RANDOM:  word_if.ready = ($urandom_range(0, 3) != 0);
      default:    word_if.ready = (rx_cnt % 20) >= 14;
    endcase
  end

  always @(posedge clk_i) begin
    word_exp_t want;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (words_due.size() == 0) begin
        $display("%0t unexpected word: expected none, got hash %h fp %h len %0d",
                 $time, word_if.word_hash, word_if.fingerprint, word_if.word_length);
        mismatch_count++;
      end else begin
        want = words_due.pop_front();
        if (word_if.word_hash !== want.hash) begin
          $display("%0t word_hash: expected %h, got %h", $time, want.hash,
                   word_if.word_hash);
          mismatch_count++;
        end
        if (word_if.fingerprint !== want.fp) begin
          $display("%0t fingerprint: expected %h, got %h", $time, want.fp,
                   word_if.fingerprint);
          mismatch_count++;
        end
        if (word_if.word_length !== want.len) begin
          $display("%0t word_length: expected %0d, got %0d", $time, want.len,
                   word_if.word_length);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned roll;
    int unsigned wlen;
    int unsigned nsep;
    int unsigned nnoise;
    bit          end_on_last;
    logic        m;
    logic [7:0]  c;

    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.byte_value = 8'h00;
    byte_if.last_byte  = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.hash_mode   = wth_pkg::MODE_CRC;
    word_if.ready      = 1'b0;
    mode_q             = wth_pkg::MODE_CRC;
    acc_q              = start_value(wth_pkg::MODE_CRC);
    held_q             = 0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_MODE: write_mode(dir_rows[i].value[0]);
        ROW_RUN:  repeat (dir_rows[i].count) send_byte(dir_rows[i].value, 1'b0, LEN_PRED);
        default:  send_byte(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].exp_len);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0)      m = wth_pkg::MODE_CRC;
      else if (phase <= 2) m = wth_pkg::MODE_FNV;
      else                 m = logic'($urandom_range(0, 1));
      write_mode(m);
      no_gaps = (phase % 3 == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          roll = $urandom_range(0, 99);
          if (roll < 90)      wlen = $urandom_range(1, 12);
          else if (roll < 97) wlen = $urandom_range(13, 40);
          else                wlen = $urandom_range(95, 110);
          end_on_last = ($urandom_range(0, 4) == 0);
          for (int k = 0; k < wlen; k++) begin
            c = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
            send_byte(c, end_on_last && (k == wlen - 1), LEN_PRED);
          end
          nsep = end_on_last ? $urandom_range(0, 1) : $urandom_range(1, 3);
          repeat (nsep) send_byte(pick_sep(), $urandom_range(0, 9) == 0, LEN_PRED);
          sent += wlen + nsep;
        end else begin
          nnoise = $urandom_range(1, 6);
          repeat (nnoise) send_byte(8'($urandom), 1'($urandom), LEN_PRED);
          sent += nnoise;
        end
      end
    end

    @(negedge clk_i);
    byte_if.valid = 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[word_tokenizer_hasher_core] OK");
    end else begin
      $display("[word_tokenizer_hasher_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t timeout", $time);
    $display("[word_tokenizer_hasher_core] ERROR");
    $finish;
  end

endmodule

// ===== word_tokenizer_hasher_core.f =====
rtl/wth_pkg.sv
rtl/wth_if.sv
rtl/wth_fifo.sv
rtl/wth_front.sv
rtl/wth_back.sv
rtl/word_tokenizer_hasher_core.sv
rtl/wth_checker.sv
dv/word_tokenizer_hasher_core_test.sv
